/* rtl/pfr_pkg.sv */
// Shared types and constants for the pixel format to RGBA32 converter.
package pfr_pkg;

  typedef enum logic [2:0] {
    FMT_BGRA = 3'd0,
    FMT_BGR  = 3'd1,
    FMT_RGBA = 3'd2,
    FMT_RGB  = 3'd3,
    FMT_ARGB = 3'd4,
    FMT_ABGR = 3'd5,
    FMT_MONO = 3'd6,
    FMT_YCC  = 3'd7
  } pfr_fmt_e;

  localparam logic [7:0] REG_PIXEL_FORMAT = 8'd0;
  localparam logic [7:0] REG_BIG_ENDIAN   = 8'd1;

  localparam int unsigned ProdW = 26;
  localparam int unsigned OffW  = 10;

  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic [7:0] byte_d;
    pfr_fmt_e   fmt;
    logic       big_endian;
  } pfr_item_t;

  typedef struct packed {
    pfr_item_t               item;
    logic signed [OffW-1:0]  off_r;
    logic signed [OffW-1:0]  off_g;
    logic signed [OffW-1:0]  off_b;
  } pfr_offs_t;

  typedef struct packed {
    logic [31:0] word0;
    logic [31:0] word1;
    logic        two;
  } pfr_words_t;

endpackage

/* rtl/pfr_chroma.sv */
// Two pipeline stages: chroma products, then truncated chroma offsets.
module pfr_chroma (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pfr_pkg::pfr_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pfr_pkg::pfr_offs_t  out_data_o
);
  import pfr_pkg::*;

  localparam logic signed [ProdW-1:0] KrQ16  = 26'sd91881;
  localparam logic signed [ProdW-1:0] KgbQ16 = 26'sd22544;
  localparam logic signed [ProdW-1:0] KgrQ16 = 26'sd46793;
  localparam logic signed [ProdW-1:0] KbQ16  = 26'sd116130;

  // Divide by 2^16, rounding toward zero.
  function automatic logic signed [OffW-1:0] trunc_q16(input logic signed [ProdW-1:0] v);
    logic [ProdW-1:0] mag;
    logic [OffW-1:0]  q;
    mag = v[ProdW-1] ? (~v + 26'd1) : v;
    q   = mag[ProdW-1:16];
    return v[ProdW-1] ? (~q + 10'd1) : q;
  endfunction

  logic signed [8:0]       cb, cr;
  logic signed [ProdW-1:0] cb_x, cr_x;

  logic                    s1_valid_q;
  pfr_item_t               s1_item_q;
  logic signed [ProdW-1:0] s1_pr_q, s1_pgb_q, s1_pgr_q, s1_pb_q;
  logic                    s1_ready;

  logic                    s2_valid_q;
  pfr_offs_t               s2_data_q, s2_data_d;
  logic signed [ProdW-1:0] g_sum, g_neg;

  assign cb   = $signed({1'b0, in_item_i.byte_c}) - 9'sd128;
  assign cr   = $signed({1'b0, in_item_i.byte_d}) - 9'sd128;
  assign cb_x = {{(ProdW-9){cb[8]}}, cb};
  assign cr_x = {{(ProdW-9){cr[8]}}, cr};

  assign s1_ready   = !s2_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
      s1_pr_q   <= KrQ16 * cr_x;
      s1_pgb_q  <= KgbQ16 * cb_x;
      s1_pgr_q  <= KgrQ16 * cr_x;
      s1_pb_q   <= KbQ16 * cb_x;
    end
  end

  assign g_sum = s1_pgb_q + s1_pgr_q;
  assign g_neg = -g_sum;

  always_comb begin
    s2_data_d.item  = s1_item_q;
    s2_data_d.off_r = trunc_q16(s1_pr_q);
    s2_data_d.off_g = trunc_q16(g_neg);
    s2_data_d.off_b = trunc_q16(s1_pb_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && s1_valid_q) begin
      s2_data_q <= s2_data_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_data_q;

endmodule

/* rtl/pfr_pack.sv */
// Pipeline stage: luma plus offset with clamping, channel swizzle, word packing.
module pfr_pack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pfr_pkg::pfr_offs_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pfr_pkg::pfr_words_t out_data_o
);
  import pfr_pkg::*;

  localparam logic [7:0] AlphaFull = 8'hff;

  function automatic logic [7:0] clamp_byte(input logic signed [OffW-1:0] v);
    if (v[OffW-1]) begin
      return 8'd0;
    end else if (v[OffW-2]) begin
      return 8'hff;
    end
    return v[7:0];
  endfunction

  function automatic logic [31:0] pack_word(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input logic be);
    return be ? {r, g, b, AlphaFull} : {AlphaFull, b, g, r};
  endfunction

  pfr_item_t              it;
  logic [7:0]             r, g, b;
  logic [7:0]             r0, g0, b0, r1, g1, b1;
  logic signed [OffW-1:0] y0, y1;
  logic                   valid_q;
  pfr_words_t             data_q, data_d;

  assign it = in_data_i.item;
  assign y0 = $signed({2'b00, it.byte_a});
  assign y1 = $signed({2'b00, it.byte_b});

  assign r0 = clamp_byte(y0 + in_data_i.off_r);
  assign g0 = clamp_byte(y0 + in_data_i.off_g);
  assign b0 = clamp_byte(y0 + in_data_i.off_b);
  assign r1 = clamp_byte(y1 + in_data_i.off_r);
  assign g1 = clamp_byte(y1 + in_data_i.off_g);
  assign b1 = clamp_byte(y1 + in_data_i.off_b);

  always_comb begin
    case (it.fmt)
      FMT_BGRA, FMT_BGR: begin
        b = it.byte_a; g = it.byte_b; r = it.byte_c;
      end
      FMT_RGBA, FMT_RGB: begin
        r = it.byte_a; g = it.byte_b; b = it.byte_c;
      end
      FMT_ARGB: begin
        r = it.byte_b; g = it.byte_c; b = it.byte_d;
      end
      FMT_ABGR: begin
        b = it.byte_b; g = it.byte_c; r = it.byte_d;
      end
      FMT_MONO: begin
        r = it.byte_a; g = it.byte_a; b = it.byte_a;
      end
      FMT_YCC: begin
        r = r0; g = g0; b = b0;
      end
      default: begin
        r = r0; g = g0; b = b0;
      end
    endcase
    data_d.word0 = pack_word(r, g, b, it.big_endian);
    data_d.word1 = pack_word(r1, g1, b1, it.big_endian);
    data_d.two   = (it.fmt == FMT_YCC);
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* rtl/pfr_serializer.sv */
// Output register: one or two words per item, one beat per cycle while out_ready_i is high.
module pfr_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pfr_pkg::pfr_words_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         pixel_word_o,
  output logic                last_of_item_o
);
  import pfr_pkg::*;

  logic       valid_q;
  logic       sel_q;
  pfr_words_t data_q;
  logic       out_fire, finish, in_fire;

  assign last_of_item_o = !data_q.two || sel_q;
  assign pixel_word_o   = sel_q ? data_q.word1 : data_q.word0;
  assign out_valid_o    = valid_q;
  assign out_fire       = valid_q && out_ready_i;
  assign finish         = out_fire && last_of_item_o;
  assign in_ready_o     = !valid_q || finish;
  assign in_fire        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (in_fire) begin
      valid_q <= 1'b1;
      sel_q   <= 1'b0;
    end else if (finish) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (out_fire) begin
      // advance to the second word
      sel_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_q <= in_data_i;
    end
  end

endmodule

/* rtl/pixel_format_to_rgba32_top.sv */
// Top level of the pixel format to RGBA32 converter.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------
//   in      | input     | in_valid_i / in_ready_o | byte_a_i, byte_b_i, byte_c_i, byte_d_i
//   out     | output    | out_valid_o/out_ready_i | pixel_word_o, last_of_item_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// An item passes four register stages (products, offsets, pack, output). The acceptance
// edge loads the products register, and the offsets, pack and output registers follow in
// that order. The output register sends one word per cycle while out_ready_i is high:
// byte formats send one word per item, YCbCr (two luma, one chroma pair) sends two.
// Reset clears all valid bits and sets both configuration registers to zero.
// A stall on the output backs up stage by stage; in_ready_o drops only when all stages
// hold a beat and the output register does not release its item in that cycle.
// Configuration is sampled with each item at acceptance.
module pixel_format_to_rgba32_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_a_i,
  input  logic [7:0]  byte_b_i,
  input  logic [7:0]  byte_c_i,
  input  logic [7:0]  byte_d_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] pixel_word_o,
  output logic        last_of_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import pfr_pkg::*;

  pfr_fmt_e   fmt_q;
  logic       big_endian_q;
  pfr_item_t  item;
  pfr_offs_t  offs;
  pfr_words_t words;
  logic       offs_valid, offs_ready, words_valid, words_ready;

  assign cfg_ready_o = 1'b1;

  // Unknown register indexes drop the write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q        <= FMT_BGRA;
      big_endian_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_PIXEL_FORMAT) begin
        fmt_q <= pfr_fmt_e'(cfg_data_i[2:0]);
      end else if (cfg_index_i == REG_BIG_ENDIAN) begin
        big_endian_q <= cfg_data_i[0];
      end
    end
  end

  always_comb begin
    item.byte_a     = byte_a_i;
    item.byte_b     = byte_b_i;
    item.byte_c     = byte_c_i;
    item.byte_d     = byte_d_i;
    item.fmt        = fmt_q;
    item.big_endian = big_endian_q;
  end

  pfr_chroma u_chroma (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (item),
    .out_valid_o (offs_valid),
    .out_ready_i (offs_ready),
    .out_data_o  (offs)
  );

  pfr_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (offs_valid),
    .in_ready_o  (offs_ready),
    .in_data_i   (offs),
    .out_valid_o (words_valid),
    .out_ready_i (words_ready),
    .out_data_o  (words)
  );

  pfr_serializer u_serializer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (words_valid),
    .in_ready_o     (words_ready),
    .in_data_i      (words),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_word_o   (pixel_word_o),
    .last_of_item_o (last_of_item_o)
  );

endmodule

/* rtl/pfr_checker.sv */
// Port-level checks for the pixel format to RGBA32 converter, bound to the top level.
module pfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] pixel_word_o,
  input logic        last_of_item_o
);

  // A stalled output beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_word_o)
                                    && $stable(last_of_item_o))
    else $error("stalled output beat changed");

  // The second word of a pair is already held and is the last one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_item_o |=> out_valid_o && last_of_item_o)
    else $error("second word of a pair missing");

  // Every word carries an opaque alpha byte at one end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixel_word_o[31:24] == 8'hff) || (pixel_word_o[7:0] == 8'hff))
    else $error("alpha byte not opaque");

  // Input backpressure only arises while the output holds a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind pixel_format_to_rgba32_top pfr_checker u_pfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .pixel_word_o   (pixel_word_o),
  .last_of_item_o (last_of_item_o)
);
